/* hdl/multidrop_slave_frame_receiver_assert.svh */
// Assertion macros used by the frame receiver core.
`ifndef MULTIDROP_SLAVE_FRAME_RECEIVER_ASSERT_SVH
`define MULTIDROP_SLAVE_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle check, disabled while reset is asserted.
`define MSFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons holds in the next cycle.
`define MSFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/msfr_pkg.sv */
// Types and constants for the multidrop slave frame receiver.
package msfr_pkg;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK_CODE        = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_STATION_ADDRESS = 8'h03;
    localparam logic [7:0] RST_COMMAND_CODE    = 8'h01;
    localparam logic [4:0] RST_PAYLOAD_LENGTH  = 5'd10;
    localparam logic [7:0] RST_ACK_CODE        = 8'hCC;
    localparam logic [7:0] RST_NAK_CODE        = 8'hDD;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] station_address;
        logic [7:0] command_code;
        logic [4:0] payload_length;
        logic [7:0] ack_code;
        logic [7:0] nak_code;
    } cfg_t;

    // Received word held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       ninth;
    } rx_item_t;

endpackage

/* hdl/msfr_cfg_regs.sv */
// Configuration register file of the frame receiver.
module msfr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output msfr_pkg::cfg_t                cfg
);

    msfr_pkg::cfg_t cfg_reg;
    msfr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                msfr_pkg::CFG_STATION_ADDRESS: cfg_next.station_address = cfg_data;
                msfr_pkg::CFG_COMMAND_CODE:    cfg_next.command_code    = cfg_data;
                msfr_pkg::CFG_PAYLOAD_LENGTH:  cfg_next.payload_length  = cfg_data[4:0];
                msfr_pkg::CFG_ACK_CODE:        cfg_next.ack_code        = cfg_data;
                msfr_pkg::CFG_NAK_CODE:        cfg_next.nak_code        = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address <= msfr_pkg::RST_STATION_ADDRESS;
            cfg_reg.command_code    <= msfr_pkg::RST_COMMAND_CODE;
            cfg_reg.payload_length  <= msfr_pkg::RST_PAYLOAD_LENGTH;
            cfg_reg.ack_code        <= msfr_pkg::RST_ACK_CODE;
            cfg_reg.nak_code        <= msfr_pkg::RST_NAK_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/msfr_in_stage.sv */
// Input register stage for received words.
module msfr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    input  logic               rx_ninth_bit,
    input  logic               take,
    output msfr_pkg::rx_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       ninth_reg;
    logic       accept;

    // Hold off the sender only while the held word cannot move on
    assign rx_stall = valid_reg && !take;
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= rx_byte;
            ninth_reg <= rx_ninth_bit;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.ninth = ninth_reg;

endmodule

/* hdl/msfr_core.sv */
// Frame state, checksum accumulation and reply register.
`include "multidrop_slave_frame_receiver_assert.svh"

module msfr_core #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msfr_pkg::rx_item_t item,
    input  msfr_pkg::cfg_t     cfg,
    output logic               take,
    output logic               reply_valid,
    input  logic               reply_stall,
    output logic [7:0]         reply_byte,
    output logic               reply_ninth_bit,
    output logic               frame_done,
    output logic               checksum_ok
);

    // Counter never exceeds min(31, MAX_PAYLOAD)
    localparam int CNT_W = (MAX_PAYLOAD >= 31) ? 5 : $clog2(MAX_PAYLOAD + 1);

    msfr_pkg::phase_t phase_reg;
    msfr_pkg::phase_t phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] eff_len;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_ninth_reg;
    logic             out_done_reg;
    logic             out_ok_reg;

    logic             emit;
    logic [7:0]       emit_byte;
    logic             emit_ninth;
    logic             emit_done;
    logic             emit_ok;

    // Word moves on when the reply slot is free or being emptied
    assign take = item.valid && (!out_valid_reg || !reply_stall);

    // Effective payload length: zero counts as one, clamp to MAX_PAYLOAD
    always_comb
    begin
        priority if (cfg.payload_length == 5'd0)
            eff_len = CNT_W'(1);
        else if ({3'b000, cfg.payload_length} > 8'(MAX_PAYLOAD))
            eff_len = CNT_W'(MAX_PAYLOAD);
        else
            eff_len = CNT_W'(cfg.payload_length);
    end

    assign cnt_inc = cnt_reg + CNT_W'(1);

    // Next state and reply for the held word
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        emit       = 1'b0;
        emit_byte  = item.data;
        emit_ninth = 1'b0;
        emit_done  = 1'b0;
        emit_ok    = 1'b0;
        unique case (phase_reg)
            msfr_pkg::PH_IDLE:
            begin
                if (item.ninth && item.data == cfg.station_address)
                begin
                    phase_next = msfr_pkg::PH_CMD;
                    cnt_next   = '0;
                    sum_next   = '0;
                    emit       = 1'b1;
                    emit_ninth = 1'b1;
                end
            end
            msfr_pkg::PH_CMD:
            begin
                if (item.data == cfg.command_code)
                begin
                    phase_next = msfr_pkg::PH_DATA;
                    cnt_next   = '0;
                    sum_next   = '0;
                    emit       = 1'b1;
                end
                else
                begin
                    phase_next = msfr_pkg::PH_IDLE;
                end
            end
            msfr_pkg::PH_DATA:
            begin
                sum_next = sum_reg + item.data;
                cnt_next = cnt_inc;
                if (cnt_inc >= eff_len)
                    phase_next = msfr_pkg::PH_SUM;
            end
            msfr_pkg::PH_SUM:
            begin
                phase_next = msfr_pkg::PH_IDLE;
                cnt_next   = '0;
                sum_next   = '0;
                emit       = 1'b1;
                emit_done  = 1'b1;
                emit_ok    = (item.data == sum_reg);
                emit_byte  = (item.data == sum_reg) ? cfg.ack_code : cfg.nak_code;
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= msfr_pkg::PH_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    // Reply register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !reply_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_byte_reg  <= emit_byte;
            out_ninth_reg <= emit_ninth;
            out_done_reg  <= emit_done;
            out_ok_reg    <= emit_ok;
        end
    end

    assign reply_valid     = out_valid_reg;
    assign reply_byte      = out_byte_reg;
    assign reply_ninth_bit = out_ninth_reg;
    assign frame_done      = out_done_reg;
    assign checksum_ok     = out_ok_reg;

    // Checks
    `MSFR_ASSERT(a_idle_clear, phase_reg != msfr_pkg::PH_IDLE || (cnt_reg == '0 && sum_reg == '0), "idle with stale count or sum")
    `MSFR_ASSERT(a_sum_counted, phase_reg != msfr_pkg::PH_SUM || cnt_reg != '0, "checksum phase without payload")
    `MSFR_ASSERT(a_no_overwrite, !(out_valid_reg && reply_stall && take), "reply overwritten while stalled")
    `MSFR_ASSERT_NEXT(a_echo_fields, take && emit && emit_ninth, reply_valid && !frame_done && !checksum_ok, "address echo fields wrong")

endmodule

/* hdl/multidrop_slave_frame_receiver.sv */
// Top level of the nine-bit multidrop slave frame receiver.
//
// Channels: rx_valid/rx_stall carries one received word (rx_byte plus
// rx_ninth_bit) per handshake; reply_valid/reply_stall carries zero or one
// reply word per received word. cfg_valid/cfg_ready with cfg_index and
// cfg_data writes the five setup registers; cfg_ready is always high and
// writes belong to idle periods only.
// Path: input register, then frame logic into the reply register; a word
// waits in the input register while a stalled reply blocks its take.
// Throughput: one word per cycle while no stalled reply blocks the take,
// set by the single state update and 8-bit add between the input register
// and the reply register.
// Reset: registers return to their defaults, the frame state goes idle and
// both stages empty.
// Receiver stall: the reply register holds its word and the frame logic
// takes nothing more, whether or not the next word gives a reply; the input
// register holds at most one more word, then rx_stall rises until the reply
// is taken.
module multidrop_slave_frame_receiver #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_stall,
    input  logic [7:0]                    rx_byte,
    input  logic                          rx_ninth_bit,
    output logic                          reply_valid,
    input  logic                          reply_stall,
    output logic [7:0]                    reply_byte,
    output logic                          reply_ninth_bit,
    output logic                          frame_done,
    output logic                          checksum_ok,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    msfr_pkg::cfg_t     cfg;
    msfr_pkg::rx_item_t item;
    logic               take;

    msfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msfr_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .rx_ninth_bit (rx_ninth_bit),
        .take         (take),
        .item         (item)
    );

    msfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .cfg             (cfg),
        .take            (take),
        .reply_valid     (reply_valid),
        .reply_stall     (reply_stall),
        .reply_byte      (reply_byte),
        .reply_ninth_bit (reply_ninth_bit),
        .frame_done      (frame_done),
        .checksum_ok     (checksum_ok)
    );

endmodule
